// ===== src/fatb_pkg.sv =====
// Package: shared types and constants of the FLV to Annex-B / ADTS framer.
`default_nettype none
package fatb_pkg;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam logic [1:0] KindVideo = 2'd0;
  localparam logic [1:0] KindAudio = 2'd1;

  localparam logic [1:0] CfgVideoDur = 2'd0;
  localparam logic [1:0] CfgAudioDur = 2'd1;

  localparam logic [7:0] KeyFrameTag = 8'h17;
  localparam logic [7:0] AdtsSync0   = 8'hFF;
  localparam logic [7:0] AdtsSync1   = 8'hF9;
  localparam logic [7:0] AdtsLast    = 8'hFC;
  localparam logic [4:0] AdtsFill    = 5'h1F;
  localparam logic [3:0] AacFormat   = 4'd10;

  typedef enum logic [1:0] {
    MODE_BYTE,
    MODE_SC3,
    MODE_SC4,
    MODE_ADTS
  } mode_t;

  // One emission job handed from the parser to the output side.
  typedef struct packed {
    mode_t       mode;
    logic [31:0] data;   // data byte in [7:0], or ADTS bytes 2..5
    logic        start;
    logic        pend;
    logic        param;
    logic        audio;
    logic        key;
    logic [31:0] pts;
    logic [31:0] dur;
  } cmd_t;

endpackage
`default_nettype wire

// ===== src/fatb_front.sv =====
// Front: parses message bytes and turns each one into at most one emission job.
`default_nettype none
module fatb_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              acc,
  input  wire logic [1:0]        kind,
  input  wire logic [7:0]        data_byte,
  input  wire logic              first_byte,
  input  wire logic              last_byte,
  input  wire logic [23:0]       body_length,
  input  wire logic [31:0]       timestamp,
  input  wire logic              timestamp_absolute,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  output logic                   push,
  output fatb_pkg::cmd_t         cmd
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_BYTE1, PH_SEQ_HDR, PH_FRAME_HDR, PH_NAL_LEN, PH_NAL_DATA,
    PH_SET_LEN_HI, PH_SET_LEN_LO, PH_SET_DATA, PH_PPS_COUNT, PH_ACFG_HI,
    PH_ACFG_LO, PH_AUDIO_DATA, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] vdur_reg, adur_reg;
  logic [23:0] body_position, body_position_next, body_len, body_len_next;
  logic [1:0]  message_kind, message_kind_next;
  logic        key_flag, key_flag_next, aac_format, aac_format_next;
  logic [31:0] msg_ts, msg_ts_next;
  logic        msg_abs, msg_abs_next;
  logic [31:0] length_shift, length_shift_next;
  logic [2:0]  nal_cnt, nal_cnt_next;
  logic [31:0] bytes_rem, bytes_rem_next;
  logic        first_nal, first_nal_next;
  logic [4:0]  set_left, set_left_next;
  logic        set_pps, set_pps_next;
  logic [7:0]  cfg_hi, cfg_hi_next;
  logic [31:0] vtime, vtime_next, atime, atime_next, pdur, pdur_next;
  logic        vtime_ok, vtime_ok_next, atime_ok, atime_ok_next;
  logic [4:0]  aac_profile, aac_profile_next;
  logic [3:0]  aac_freq, aac_freq_next, aac_ch, aac_ch_next;
  logic        pkt_open, pkt_open_next, start_pend, start_pend_next;

  logic        end_m;
  logic [23:0] pos;
  logic [12:0] alen;
  logic [4:0]  prof_m1;
  fatb_pkg::mode_t c_mode;
  logic [31:0] c_data;
  logic        c_start, c_pend, c_param, c_push;

  always_comb begin
    phase_next = phase; body_position_next = body_position; body_len_next = body_len;
    message_kind_next = message_kind; key_flag_next = key_flag;
    aac_format_next = aac_format; msg_ts_next = msg_ts; msg_abs_next = msg_abs;
    length_shift_next = length_shift; nal_cnt_next = nal_cnt;
    bytes_rem_next = bytes_rem; first_nal_next = first_nal;
    set_left_next = set_left; set_pps_next = set_pps; cfg_hi_next = cfg_hi;
    vtime_next = vtime; atime_next = atime; pdur_next = pdur;
    vtime_ok_next = vtime_ok; atime_ok_next = atime_ok;
    aac_profile_next = aac_profile; aac_freq_next = aac_freq; aac_ch_next = aac_ch;
    pkt_open_next = pkt_open; start_pend_next = start_pend;
    c_push = 1'b0; c_mode = fatb_pkg::MODE_BYTE; c_data = 32'd0;
    c_start = 1'b0; c_pend = 1'b0; c_param = 1'b0;
    end_m = 1'b0;
    pos = body_position + 24'd1;
    alen = body_len[12:0] + 13'd5;
    prof_m1 = aac_profile - 5'd1;
    if (acc && first_byte) begin
      pkt_open_next = 1'b0;
      start_pend_next = 1'b0;
      body_len_next = body_length;
      msg_ts_next = timestamp;
      msg_abs_next = timestamp_absolute;
      message_kind_next = kind;
      body_position_next = 24'd0;
      phase_next = (!kind[1] && body_length != 24'd0) ? PH_BYTE1 : PH_IDLE;
      if (!kind[1] && body_length != 24'd0) begin
        key_flag_next = (data_byte == fatb_pkg::KeyFrameTag);
        aac_format_next = (data_byte[7:4] == fatb_pkg::AacFormat);
      end
      if (last_byte || body_length <= 24'd1) phase_next = PH_IDLE;
    end else if (acc && phase != PH_IDLE) begin
      body_position_next = pos;
      end_m = last_byte || ({1'b0, pos} + 25'd1 >= {1'b0, body_len});
      case (phase)
        PH_BYTE1: begin
          if (message_kind == fatb_pkg::KindVideo) begin
            if (key_flag && data_byte == 8'd0) begin
              phase_next = PH_SEQ_HDR;
            end else begin
              pdur_next = {16'd0, vdur_reg};
              if (!vtime_ok) begin
                vtime_next = msg_ts; vtime_ok_next = 1'b1;
              end else if (msg_abs) begin
                vtime_next = msg_ts;
              end else begin
                pdur_next = msg_ts; vtime_next = vtime + msg_ts;
              end
              phase_next = PH_FRAME_HDR;
            end
          end else if (data_byte == 8'd0) begin
            phase_next = aac_format ? PH_ACFG_HI : PH_DONE;
          end else begin
            pdur_next = {16'd0, adur_reg};
            if (!atime_ok) begin
              atime_next = msg_ts; atime_ok_next = 1'b1;
            end else if (msg_abs) begin
              atime_next = msg_ts;
            end else begin
              pdur_next = msg_ts; atime_next = atime + msg_ts;
            end
            pkt_open_next = 1'b1;
            c_push = 1'b1; c_mode = fatb_pkg::MODE_ADTS; c_start = 1'b1;
            start_pend_next = 1'b0;
            c_data = {prof_m1[1:0], aac_freq, 1'b0, aac_ch[2],
                      aac_ch[1:0], 4'd0, alen[12:11],
                      alen[10:3],
                      alen[2:0], fatb_pkg::AdtsFill};
            phase_next = PH_AUDIO_DATA;
          end
        end
        PH_SEQ_HDR: begin
          if (pos == 24'd10) begin
            set_left_next = data_byte[4:0];
            set_pps_next = 1'b0;
            first_nal_next = 1'b1;
            phase_next = (data_byte[4:0] != 5'd0) ? PH_SET_LEN_HI : PH_PPS_COUNT;
          end
        end
        PH_PPS_COUNT: begin
          set_left_next = data_byte[4:0];
          set_pps_next = 1'b1;
          first_nal_next = 1'b1;
          phase_next = (data_byte[4:0] != 5'd0) ? PH_SET_LEN_HI : PH_DONE;
        end
        PH_SET_LEN_HI: begin
          cfg_hi_next = data_byte;
          phase_next = PH_SET_LEN_LO;
        end
        PH_SET_LEN_LO, PH_SET_DATA: begin
          if (phase == PH_SET_LEN_LO) begin
            bytes_rem_next = {16'd0, cfg_hi, data_byte};
            if (first_nal) begin
              pkt_open_next = 1'b1;
              c_push = 1'b1; c_mode = fatb_pkg::MODE_SC4; c_param = 1'b1;
              c_start = 1'b1; start_pend_next = 1'b0;
            end
          end else begin
            if (first_nal) begin
              c_push = 1'b1; c_mode = fatb_pkg::MODE_BYTE; c_param = 1'b1;
              c_data = {24'd0, data_byte};
              c_start = start_pend; start_pend_next = 1'b0;
            end
            bytes_rem_next = bytes_rem - 32'd1;
          end
          if (bytes_rem_next == 32'd0) begin
            // this set is finished: only the first of each list is sent
            if (first_nal) begin
              if (pkt_open_next && c_push) c_pend = 1'b1;
              pkt_open_next = 1'b0;
              start_pend_next = 1'b0;
            end
            first_nal_next = 1'b0;
            set_left_next = set_left - 5'd1;
            if (set_left_next != 5'd0) phase_next = PH_SET_LEN_HI;
            else phase_next = set_pps ? PH_DONE : PH_PPS_COUNT;
          end else if (phase == PH_SET_LEN_LO) begin
            phase_next = PH_SET_DATA;
          end
        end
        PH_FRAME_HDR: begin
          if (pos == 24'd4) begin
            phase_next = PH_NAL_LEN;
            length_shift_next = 32'd0;
            nal_cnt_next = 3'd0;
            first_nal_next = 1'b1;
          end
        end
        PH_NAL_LEN: begin
          length_shift_next = {length_shift[23:0], data_byte};
          nal_cnt_next = nal_cnt + 3'd1;
          if (nal_cnt_next >= 3'd4 || end_m) begin
            c_push = 1'b1;
            c_mode = first_nal ? fatb_pkg::MODE_SC4 : fatb_pkg::MODE_SC3;
            c_start = first_nal | start_pend;
            if (first_nal) pkt_open_next = 1'b1;
            start_pend_next = 1'b0;
            first_nal_next = 1'b0;
            bytes_rem_next = length_shift_next;
            length_shift_next = 32'd0;
            nal_cnt_next = 3'd0;
            if (bytes_rem_next != 32'd0) phase_next = PH_NAL_DATA;
          end
        end
        PH_NAL_DATA: begin
          c_push = 1'b1; c_data = {24'd0, data_byte};
          c_start = start_pend; start_pend_next = 1'b0;
          bytes_rem_next = bytes_rem - 32'd1;
          if (bytes_rem_next == 32'd0) phase_next = PH_NAL_LEN;
        end
        PH_ACFG_HI: begin
          cfg_hi_next = data_byte;
          phase_next = PH_ACFG_LO;
        end
        PH_ACFG_LO: begin
          aac_profile_next = cfg_hi[7:3];
          aac_freq_next = {cfg_hi[2:0], data_byte[7]};
          aac_ch_next = data_byte[6:3];
          phase_next = PH_DONE;
        end
        PH_AUDIO_DATA: begin
          c_push = 1'b1; c_data = {24'd0, data_byte};
          c_start = start_pend; start_pend_next = 1'b0;
        end
        default: begin
        end
      endcase
      if (end_m) begin
        if (pkt_open_next && c_push) c_pend = 1'b1;
        pkt_open_next = 1'b0;
        start_pend_next = 1'b0;
        phase_next = PH_IDLE;
      end
    end
  end

  always_comb begin
    push = c_push;
    cmd.mode = c_mode;
    cmd.data = c_data;
    cmd.start = c_start;
    cmd.pend = c_pend;
    cmd.param = c_param;
    cmd.audio = (message_kind_next == fatb_pkg::KindAudio);
    cmd.key = (message_kind_next != fatb_pkg::KindAudio) && key_flag_next;
    cmd.pts = c_param ? 32'd0 :
              ((message_kind_next == fatb_pkg::KindAudio) ? atime_next : vtime_next);
    cmd.dur = c_param ? 32'd0 : pdur_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; vdur_reg <= 16'd0; adur_reg <= 16'd0;
      body_position <= 24'd0; body_len <= 24'd0; message_kind <= 2'd0;
      key_flag <= 1'b0; aac_format <= 1'b0; msg_ts <= 32'd0; msg_abs <= 1'b0;
      length_shift <= 32'd0; nal_cnt <= 3'd0; bytes_rem <= 32'd0;
      first_nal <= 1'b1; set_left <= 5'd0; set_pps <= 1'b0; cfg_hi <= 8'd0;
      vtime <= 32'd0; atime <= 32'd0; pdur <= 32'd0;
      vtime_ok <= 1'b0; atime_ok <= 1'b0;
      aac_profile <= 5'd0; aac_freq <= 4'd0; aac_ch <= 4'd0;
      pkt_open <= 1'b0; start_pend <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == fatb_pkg::CfgVideoDur) vdur_reg <= cfg_data;
      if (cfg_we && cfg_index == fatb_pkg::CfgAudioDur) adur_reg <= cfg_data;
      phase <= phase_next; body_position <= body_position_next;
      body_len <= body_len_next; message_kind <= message_kind_next;
      key_flag <= key_flag_next; aac_format <= aac_format_next;
      msg_ts <= msg_ts_next; msg_abs <= msg_abs_next;
      length_shift <= length_shift_next; nal_cnt <= nal_cnt_next;
      bytes_rem <= bytes_rem_next; first_nal <= first_nal_next;
      set_left <= set_left_next; set_pps <= set_pps_next; cfg_hi <= cfg_hi_next;
      vtime <= vtime_next; atime <= atime_next; pdur <= pdur_next;
      vtime_ok <= vtime_ok_next; atime_ok <= atime_ok_next;
      aac_profile <= aac_profile_next; aac_freq <= aac_freq_next;
      aac_ch <= aac_ch_next; pkt_open <= pkt_open_next; start_pend <= start_pend_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/fatb_queue.sv =====
// Queue: short job FIFO between the parser and the output side.
`default_nettype none
module fatb_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  fatb_pkg::cmd_t      din,
  input  wire logic           pop,
  output fatb_pkg::cmd_t      dout,
  output logic                full,
  output logic                empty
);

  fatb_pkg::cmd_t mem [fatb_pkg::QueueDepth];
  logic [fatb_pkg::QueuePtrW-1:0] wptr, rptr;
  logic [fatb_pkg::QueuePtrW:0]   count;

  assign full  = (count == (fatb_pkg::QueuePtrW+1)'(fatb_pkg::QueueDepth));
  assign empty = (count == '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (fatb_pkg::QueuePtrW+1)'(fatb_pkg::QueueDepth))
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ===== src/fatb_back.sv =====
// Back: expands jobs into output bytes through a registered output stage.
`default_nettype none
module fatb_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  fatb_pkg::cmd_t     cmd,
  input  wire logic          empty,
  output logic               pop,
  output logic               valid,
  input  wire logic          stall,
  output logic [7:0]         out_byte,
  output logic               out_stream,
  output logic               packet_start,
  output logic               packet_end,
  output logic               is_param_set,
  output logic               keyframe,
  output logic [31:0]        pts,
  output logic [31:0]        duration,
  output logic               run_last
);

  logic [2:0] idx;
  logic [2:0] last_idx;
  logic [7:0] sel;
  logic       adv, take, at_last;

  always_comb begin
    case (cmd.mode)
      fatb_pkg::MODE_SC3:  last_idx = 3'd2;
      fatb_pkg::MODE_SC4:  last_idx = 3'd3;
      fatb_pkg::MODE_ADTS: last_idx = 3'd6;
      default:             last_idx = 3'd0;
    endcase
    at_last = (idx == last_idx);
    case (cmd.mode)
      fatb_pkg::MODE_SC3, fatb_pkg::MODE_SC4: sel = at_last ? 8'd1 : 8'd0;
      fatb_pkg::MODE_ADTS: begin
        case (idx)
          3'd0: sel = fatb_pkg::AdtsSync0;
          3'd1: sel = fatb_pkg::AdtsSync1;
          3'd2: sel = cmd.data[31:24];
          3'd3: sel = cmd.data[23:16];
          3'd4: sel = cmd.data[15:8];
          3'd5: sel = cmd.data[7:0];
          default: sel = fatb_pkg::AdtsLast;
        endcase
      end
      default: sel = cmd.data[7:0];
    endcase
  end

  assign adv  = !valid || !stall;
  assign take = adv && !empty;
  assign pop  = take && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx <= 3'd0;
    end else if (adv) begin
      valid <= !empty;
      if (take) idx <= at_last ? 3'd0 : idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte <= sel;
      out_stream <= cmd.audio;
      packet_start <= cmd.start && (idx == 3'd0);
      packet_end <= cmd.pend && at_last;
      is_param_set <= cmd.param;
      keyframe <= cmd.key;
      pts <= cmd.pts;
      duration <= cmd.dur;
      run_last <= at_last;
    end
  end

endmodule
`default_nettype wire

// ===== src/flv_tag_to_annexb_adts.sv =====
// Top level: FLV media body to H.264 Annex-B and AAC ADTS byte stream framer.
`default_nettype none
// Takes one message body byte per cycle while in_stall is low and emits elementary stream bytes.
// Plain body bytes pass at one per cycle while out_stall is low; an input that turns into a start
// code (3 or 4 bytes) or an ADTS header (7 bytes) occupies the output side until
// all of its bytes are out, and a 4-entry job queue between parser and output stage
// absorbs the burst, so input stalls only when the queue fills. Configuration
// writes are always accepted (cfg_ready is tied high).
module flv_tag_to_annexb_adts (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_byte,
  input  wire logic        last_byte,
  input  wire logic [23:0] body_length,
  input  wire logic [31:0] timestamp,
  input  wire logic        timestamp_absolute,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_stream,
  output logic             packet_start,
  output logic             packet_end,
  output logic             is_param_set,
  output logic             keyframe,
  output logic [31:0]      pts,
  output logic [31:0]      duration,
  output logic             run_last
);

  fatb_pkg::cmd_t push_cmd, head_cmd;
  logic push, pop, full, empty, acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign acc       = in_valid && !in_stall;

  fatb_front u_front (
    .clk, .rst, .acc, .kind, .data_byte, .first_byte, .last_byte, .body_length,
    .timestamp, .timestamp_absolute,
    .cfg_we(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .push, .cmd(push_cmd)
  );

  fatb_queue u_queue (
    .clk, .rst, .push, .din(push_cmd), .pop, .dout(head_cmd), .full, .empty
  );

  fatb_back u_back (
    .clk, .rst, .cmd(head_cmd), .empty, .pop, .valid(out_valid), .stall(out_stall),
    .out_byte, .out_stream, .packet_start, .packet_end, .is_param_set, .keyframe,
    .pts, .duration, .run_last
  );

endmodule
`default_nettype wire

// ===== tb/sv/flv_tag_to_annexb_adts_test.sv =====
// Testbench: FLV body to Annex-B / ADTS framer, with a bit-accurate framing predictor.
`default_nettype none
module flv_tag_to_annexb_adts_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KindOther   = 2'd2;
  localparam logic [1:0] KindSpare   = 2'd3;
  localparam int         SettleCycles = 24;

  typedef enum int {
    PH_IDLE, PH_BYTE1, PH_SEQ_HDR, PH_FRAME_HDR, PH_NAL_LEN, PH_NAL_DATA,
    PH_SET_LEN_HI, PH_SET_LEN_LO, PH_SET_DATA, PH_PPS_COUNT, PH_ACFG_HI,
    PH_ACFG_LO, PH_AUDIO_DATA, PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        strm;
    logic        pstart;
    logic        pend;
    logic        param;
    logic        key;
    logic [31:0] pts;
    logic [31:0] dur;
    logic        rlast;
  } es_byte_t;

  logic        clk, rst;
  logic        in_valid, in_stall;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        first_byte, last_byte;
  logic [23:0] body_length;
  logic [31:0] timestamp;
  logic        timestamp_absolute;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        out_valid, out_stall;
  logic [7:0]  out_byte;
  logic        out_stream, packet_start, packet_end, is_param_set, keyframe;
  logic [31:0] pts, duration;
  logic        run_last;

  flv_tag_to_annexb_adts i_dut (.*);

  // framer state mirror
  logic [15:0] vdur_reg, adur_reg;
  logic [23:0] body_pos, blen_r;
  logic [1:0]  mkind;
  bit          key_r, first_nal, vtime_ok, atime_ok, msg_abs, is_aac, in_pps;
  bit          pkt_open, start_pend;
  phase_t      ph;
  logic [31:0] len_acc, remain, vtime, atime, pdur, msg_ts;
  logic [4:0]  sets_left, prof;
  logic [3:0]  freq, chans;
  logic [7:0]  hi_byte;
  int          nal_cnt;

  es_byte_t step_out[$];
  es_byte_t es_expected[$];
  logic [7:0] msg_bytes[$];

  bit quiet;
  int errors, n_items, n_results, n_msgs;

  task automatic add_msg_byte(input logic [7:0] v);
    msg_bytes.insert(msg_bytes.size(), v);
  endtask

  task automatic put_byte(input logic [7:0] b, input bit param);
    es_byte_t r;
    bit audio;
    audio = (mkind == fatb_pkg::KindAudio);
    r.b = b;
    r.strm = audio;
    r.pstart = start_pend;
    r.pend = 0;
    r.param = param;
    r.key = !audio && key_r;
    r.pts = param ? 32'd0 : (audio ? atime : vtime);
    r.dur = param ? 32'd0 : pdur;
    r.rlast = 0;
    start_pend = 0;
    step_out.insert(step_out.size(), r);
  endtask

  task automatic close_pkt();
    if (pkt_open && step_out.size() > 0) step_out[step_out.size()-1].pend = 1;
    pkt_open = 0;
    start_pend = 0;
  endtask

  task automatic start_code(input bit four, input bit param);
    if (four) put_byte(8'h00, param);
    put_byte(8'h00, param);
    put_byte(8'h00, param);
    put_byte(8'h01, param);
  endtask

  task automatic next_set();
    if (first_nal) close_pkt();
    first_nal = 0;
    sets_left = sets_left - 5'd1;
    if (sets_left != 0) ph = PH_SET_LEN_HI;
    else ph = in_pps ? PH_DONE : PH_PPS_COUNT;
  endtask

  task automatic advance_time(input bit audio);
    pdur = audio ? 32'(adur_reg) : 32'(vdur_reg);
    if (audio) begin
      if (!atime_ok) begin
        atime = msg_ts;
        atime_ok = 1;
      end else if (msg_abs) atime = msg_ts;
      else begin
        pdur = msg_ts;
        atime = atime + msg_ts;
      end
    end else begin
      if (!vtime_ok) begin
        vtime = msg_ts;
        vtime_ok = 1;
      end else if (msg_abs) vtime = msg_ts;
      else begin
        pdur = msg_ts;
        vtime = vtime + msg_ts;
      end
    end
  endtask

  task automatic framer_reset();
    vdur_reg = 0; adur_reg = 0; body_pos = 0; blen_r = 0; mkind = 0; key_r = 0;
    ph = PH_IDLE; len_acc = 0; remain = 0; first_nal = 1; sets_left = 0;
    vtime = 0; vtime_ok = 0; atime = 0; atime_ok = 0; prof = 0; freq = 0; chans = 0;
    hi_byte = 0; pdur = 0; msg_ts = 0; msg_abs = 0; is_aac = 0; in_pps = 0;
    nal_cnt = 0; pkt_open = 0; start_pend = 0;
  endtask

  // Works out the stream bytes one accepted body byte produces.
  task automatic frame_byte(input logic [1:0] k, input logic [7:0] b, input bit first,
                            input bit last, input logic [23:0] blen,
                            input logic [31:0] ts, input bit abs_ts);
    logic [31:0] p, alen, cfg;
    bit fin;
    step_out.delete();
    if (first) begin
      pkt_open = 0;
      start_pend = 0;
      blen_r = blen;
      msg_ts = ts;
      msg_abs = abs_ts;
      mkind = k;
      body_pos = 0;
      ph = (k < 2 && blen != 0) ? PH_BYTE1 : PH_IDLE;
      if (ph == PH_BYTE1) begin
        key_r = (b == fatb_pkg::KeyFrameTag);
        is_aac = (b[7:4] == fatb_pkg::AacFormat);
      end
      if (last || blen <= 1) ph = PH_IDLE;
    end else if (ph != PH_IDLE) begin
      body_pos = body_pos + 24'd1;
      p = 32'(body_pos);
      fin = last || (p + 1 >= 32'(blen_r));
      case (ph)
        PH_BYTE1: begin
          if (mkind == fatb_pkg::KindVideo) begin
            if (key_r && b == 0) ph = PH_SEQ_HDR;
            else begin
              advance_time(0);
              ph = PH_FRAME_HDR;
            end
          end else if (b == 0) begin
            ph = is_aac ? PH_ACFG_HI : PH_DONE;
          end else begin
            alen = (32'(blen_r) + 5) & 32'h1FFF;
            advance_time(1);
            pkt_open = 1;
            start_pend = 1;
            put_byte(fatb_pkg::AdtsSync0, 0);
            put_byte(fatb_pkg::AdtsSync1, 0);
            put_byte({2'((32'(prof) - 1) & 3), freq, 1'b0, chans[2]}, 0);
            put_byte({chans[1:0], 4'd0, alen[12:11]}, 0);
            put_byte(alen[10:3], 0);
            put_byte({alen[2:0], fatb_pkg::AdtsFill}, 0);
            put_byte(fatb_pkg::AdtsLast, 0);
            ph = PH_AUDIO_DATA;
          end
        end
        PH_SEQ_HDR: if (p == 10) begin
          sets_left = b[4:0];
          in_pps = 0;
          first_nal = 1;
          ph = (sets_left != 0) ? PH_SET_LEN_HI : PH_PPS_COUNT;
        end
        PH_PPS_COUNT: begin
          sets_left = b[4:0];
          in_pps = 1;
          first_nal = 1;
          ph = (sets_left != 0) ? PH_SET_LEN_HI : PH_DONE;
        end
        PH_SET_LEN_HI: begin
          hi_byte = b;
          ph = PH_SET_LEN_LO;
        end
        PH_SET_LEN_LO: begin
          remain = {16'd0, hi_byte, b};
          if (first_nal) begin
            pkt_open = 1;
            start_pend = 1;
            start_code(1, 1);
          end
          if (remain == 0) next_set();
          else ph = PH_SET_DATA;
        end
        PH_SET_DATA: begin
          if (first_nal) put_byte(b, 1);
          remain = remain - 1;
          if (remain == 0) next_set();
        end
        PH_FRAME_HDR: if (p == 4) begin
          ph = PH_NAL_LEN;
          len_acc = 0;
          nal_cnt = 0;
          first_nal = 1;
        end
        PH_NAL_LEN: begin
          len_acc = {len_acc[23:0], b};
          nal_cnt++;
          if (nal_cnt >= 4 || fin) begin
            if (first_nal) begin
              pkt_open = 1;
              start_pend = 1;
            end
            start_code(first_nal, 0);
            first_nal = 0;
            remain = len_acc;
            len_acc = 0;
            nal_cnt = 0;
            if (remain != 0) ph = PH_NAL_DATA;
          end
        end
        PH_NAL_DATA: begin
          put_byte(b, 0);
          remain = remain - 1;
          if (remain == 0) ph = PH_NAL_LEN;
        end
        PH_ACFG_HI: begin
          hi_byte = b;
          ph = PH_ACFG_LO;
        end
        PH_ACFG_LO: begin
          cfg = {16'd0, hi_byte, b};
          prof = cfg[15:11];
          freq = cfg[10:7];
          chans = cfg[6:3];
          ph = PH_DONE;
        end
        PH_AUDIO_DATA: put_byte(b, 0);
        default: ;
      endcase
      if (fin) begin
        close_pkt();
        ph = PH_IDLE;
      end
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].rlast = 1;
    foreach (step_out[i]) es_expected.insert(es_expected.size(), step_out[i]);
  endtask

  // Sends one body byte; returns at the accepting edge.
  task automatic send_item(input logic [1:0] k, input logic [7:0] b, input bit first,
                           input bit last, input logic [23:0] blen,
                           input logic [31:0] ts, input bit abs_ts);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 36) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    kind <= k;
    data_byte <= b;
    first_byte <= first;
    last_byte <= last;
    body_length <= blen;
    timestamp <= ts;
    timestamp_absolute <= abs_ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_byte(k, b, first, last, blen, ts, abs_ts);
    n_items++;
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_valid <= 0;
  endtask

  // Sends msg_bytes as one message; blen overrides the true size when it is zero or more.
  task automatic send_msg(input logic [1:0] k, input logic [31:0] ts, input bit abs_ts,
                          input bit mark_last, input int blen = -1);
    logic [23:0] bl;
    bl = (blen < 0) ? 24'(msg_bytes.size()) : 24'(blen);
    foreach (msg_bytes[i])
      send_item(k, msg_bytes[i], i == 0, mark_last && i == msg_bytes.size() - 1,
                (i == 0) ? bl : 24'($urandom), (i == 0) ? ts : $urandom,
                (i == 0) ? abs_ts : 1'($urandom));
    msg_bytes.delete();
    n_msgs++;
  endtask

  task automatic drain();
    hold_input();
    while (es_expected.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == fatb_pkg::CfgVideoDur) vdur_reg = val;
    else if (idx == fatb_pkg::CfgAudioDur) adur_reg = val;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic set_durations(input logic [15:0] v, input logic [15:0] a);
    drain();
    write_reg(fatb_pkg::CfgVideoDur, v);
    write_reg(fatb_pkg::CfgAudioDur, a);
  endtask

  task automatic put_sets(input int cnt, input int maxlen, input logic [2:0] top);
    int len;
    add_msg_byte({top, 5'(cnt)});
    for (int s = 0; s < cnt; s++) begin
      len = $urandom_range(maxlen);
      add_msg_byte(8'(len >> 8));
      add_msg_byte(8'(len));
      repeat (len) add_msg_byte(8'($urandom));
    end
  endtask

  task automatic put_seq_hdr(input int n_sps, input int n_pps, input int maxlen);
    add_msg_byte(fatb_pkg::KeyFrameTag);
    add_msg_byte(8'h00);
    repeat (8) add_msg_byte(8'($urandom));
    put_sets(n_sps, maxlen, 3'($urandom));
    put_sets(n_pps, maxlen, 3'($urandom));
  endtask

  task automatic put_video_frame(input bit key, input int n_nal, input int maxlen);
    int len;
    add_msg_byte(key ? fatb_pkg::KeyFrameTag : 8'($urandom_range(255)));
    add_msg_byte(8'($urandom_range(255, 1)));
    repeat (3) add_msg_byte(8'($urandom));
    repeat (n_nal) begin
      len = $urandom_range(maxlen);
      add_msg_byte(8'(len >> 24));
      add_msg_byte(8'(len >> 16));
      add_msg_byte(8'(len >> 8));
      add_msg_byte(8'(len));
      repeat (len) add_msg_byte(8'($urandom));
    end
  endtask

  task automatic put_aac_cfg(input logic [4:0] p, input logic [3:0] f, input logic [3:0] c);
    logic [15:0] cfg;
    cfg = {p, f, c, 3'($urandom)};
    add_msg_byte({fatb_pkg::AacFormat, 4'($urandom)});
    add_msg_byte(8'h00);
    add_msg_byte(cfg[15:8]);
    add_msg_byte(cfg[7:0]);
  endtask

  task automatic put_audio_frame(input int n);
    add_msg_byte({fatb_pkg::AacFormat, 4'($urandom)});
    add_msg_byte(8'($urandom_range(255, 1)));
    repeat (n) add_msg_byte(8'($urandom));
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    es_byte_t e;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (es_expected.size() == 0) begin
        $error("output byte 0x%0h with nothing expected", out_byte);
        errors++;
      end else begin
        e = es_expected.pop_front();
        check_field("out_byte", e.b, out_byte);
        check_field("out_stream", e.strm, out_stream);
        check_field("packet_start", e.pstart, packet_start);
        check_field("packet_end", e.pend, packet_end);
        check_field("is_param_set", e.param, is_param_set);
        check_field("keyframe", e.key, keyframe);
        check_field("pts", e.pts, pts);
        check_field("duration", e.dur, duration);
        check_field("run_last", e.rlast, run_last);
      end
    end
  end

  always @(negedge clk) out_stall <= !quiet && ($urandom_range(99) < 36);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic test_param_sets();
    put_seq_hdr(1, 1, 4);
    send_msg(fatb_pkg::KindVideo, 32'd0, 1, 1);
    put_seq_hdr(2, 3, 3);  // only the first set of each list comes out
    send_msg(fatb_pkg::KindVideo, 32'd0, 0, 0);
    put_seq_hdr(0, 1, 2);  // empty SPS list
    send_msg(fatb_pkg::KindVideo, 32'd0, 1, 1);
    put_seq_hdr(1, 0, 2);
    send_msg(fatb_pkg::KindVideo, 32'd0, 1, 1);
    put_seq_hdr(1, 1, 0);  // zero-length sets
    send_msg(fatb_pkg::KindVideo, 32'd0, 1, 1);
  endtask

  task automatic test_video_frames();
    put_video_frame(1, 2, 3);
    send_msg(fatb_pkg::KindVideo, 32'hFFFF_FFFF, 1, 1);
    put_video_frame(0, 3, 2);
    send_msg(fatb_pkg::KindVideo, 32'h0000_0010, 0, 0);  // delta wraps time
    put_video_frame(0, 1, 0);
    send_msg(fatb_pkg::KindVideo, 32'd0, 0, 1);
  endtask

  task automatic test_audio();
    put_aac_cfg(5'd0, 4'd0, 4'd0);
    send_msg(fatb_pkg::KindAudio, 32'd0, 1, 1);
    put_audio_frame(3);
    send_msg(fatb_pkg::KindAudio, 32'd100, 1, 1);
    put_aac_cfg(5'h1F, 4'hF, 4'hF);
    send_msg(fatb_pkg::KindAudio, 32'd0, 1, 1);
    put_audio_frame(2);
    send_msg(fatb_pkg::KindAudio, 32'hFFFF_FFF0, 0, 0);
    msg_bytes = '{8'h2F, 8'h00, 8'hFF, 8'hFF};  // non-AAC config is skipped
    send_msg(fatb_pkg::KindAudio, 32'd0, 1, 1);
    put_audio_frame(1);
    send_msg(fatb_pkg::KindAudio, 32'd5, 0, 1);
  endtask

  task automatic test_corner_cases();
    send_item(fatb_pkg::KindVideo, 8'h55, 0, 0, 24'd9, 32'd0, 0);  // stray byte while idle
    put_video_frame(1, 1, 40);  // body_length overstates the message, ends on last_byte
    send_msg(fatb_pkg::KindVideo, 32'd7, 0, 1, 24'hFF_FFFF);
    put_video_frame(0, 1, 2);
    add_msg_byte(8'h00);  // partial length at body end
    add_msg_byte(8'h00);
    send_msg(fatb_pkg::KindVideo, 32'd3, 0, 1);
    put_video_frame(0, 1, 6);
    send_msg(fatb_pkg::KindVideo, 32'd3, 0, 0, 12);  // cut by body_length
    put_seq_hdr(1, 1, 8);
    send_msg(fatb_pkg::KindVideo, 32'd0, 1, 0, 16);
    put_audio_frame(5);  // cut open by the next message
    msg_bytes = msg_bytes[0:3];
    send_msg(fatb_pkg::KindAudio, 32'd1, 0, 0, 30);
    msg_bytes = '{8'h17, 8'h01};
    send_msg(fatb_pkg::KindVideo, 32'd1, 0, 0, 0);  // zero-size message ignored
    msg_bytes = '{8'hAF, 8'h01, 8'h22};
    send_msg(KindOther, 32'd1, 0, 1);
    msg_bytes = '{8'h17, 8'h01, 8'h22};
    send_msg(KindSpare, 32'd1, 0, 1);
    msg_bytes = '{8'h27};
    send_msg(fatb_pkg::KindVideo, 32'd1, 0, 1);
    put_video_frame(0, 0, 0);  // ends inside the frame header
    send_msg(fatb_pkg::KindVideo, 32'd1, 0, 1);
  endtask

  task automatic test_random_streams(input int target);
    int stop_at, pick;
    logic [1:0] k;
    stop_at = n_items + target;
    while (n_items < stop_at) begin
      pick = $urandom_range(99);
      k = fatb_pkg::KindVideo;
      if (pick < 15) put_seq_hdr($urandom_range(2), $urandom_range(2), 5);
      else if (pick < 45) put_video_frame($urandom_range(1), $urandom_range(3), 6);
      else if (pick < 55) begin
        put_aac_cfg(5'($urandom), 4'($urandom), 4'($urandom));
        k = fatb_pkg::KindAudio;
      end else if (pick < 85) begin
        put_audio_frame($urandom_range(6));
        k = fatb_pkg::KindAudio;
      end else begin
        repeat ($urandom_range(6, 1)) add_msg_byte(8'($urandom));
        k = 2'($urandom);
      end
      if (pick >= 85 || $urandom_range(9) == 0)
        send_msg(k, $urandom, $urandom_range(1), $urandom_range(1),
                 $urandom_range(msg_bytes.size() + 2));
      else
        send_msg(k, $urandom_range(3) == 0 ? $urandom : $urandom_range(50),
                 $urandom_range(3) == 0, $urandom_range(1));
      if ($urandom_range(15) == 0)
        send_item(2'($urandom), 8'($urandom), 0, 1'($urandom), 24'($urandom),
                  $urandom, 1'($urandom));
    end
  endtask

  initial begin
    errors = 0; n_items = 0; n_results = 0; n_msgs = 0;
    quiet = 0;
    framer_reset();
    rst <= 1;
    in_valid <= 0; kind <= 0; data_byte <= 0; first_byte <= 0; last_byte <= 0;
    body_length <= 0; timestamp <= 0; timestamp_absolute <= 0;
    cfg_valid <= 0; cfg_index <= 0; cfg_data <= 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    set_durations(16'd0, 16'hFFFF);
    test_param_sets();
    test_video_frames();
    test_audio();
    set_durations(16'hFFFF, 16'd0);
    test_corner_cases();
    test_video_frames();
    test_audio();
    set_durations(16'd33, 16'd21);
    test_random_streams(30);
    drain();  // sender holds off until all output is out
    quiet = 1;
    test_random_streams(40);
    quiet = 0;
    set_durations(16'($urandom), 16'($urandom));
    test_random_streams(20);
    drain();

    $display("Sent %0d body bytes in %0d messages, checked %0d stream bytes",
             n_items, n_msgs, n_results);
    $display("Covered param sets, NAL framing, ADTS headers, truncation, timing");
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
